FILE: hw/rtl/twtt_pkg.sv
package twtt_pkg;

	localparam logic [1:0] FN_REGISTER = 2'd0;
	localparam logic [1:0] FN_SLEEP    = 2'd1;
	localparam logic [1:0] FN_WAIT     = 2'd2;
	localparam logic [1:0] FN_SCAN     = 2'd3;

	localparam logic [1:0] UNIT_MS  = 2'd0;
	localparam logic [1:0] UNIT_SEC = 2'd1;
	localparam logic [1:0] UNIT_MIN = 2'd2;
	localparam logic [1:0] UNIT_BAD = 2'd3;

	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_SLEEP = 2'd1;
	localparam logic [1:0] MODE_WAIT  = 2'd2;

	localparam logic [2:0] EV_IDLE    = 3'd0;
	localparam logic [2:0] EV_RUN     = 3'd1;
	localparam logic [2:0] EV_EXPIRED = 3'd2;
	localparam logic [2:0] EV_COND    = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;
	localparam logic [2:0] EV_GRANTED = 3'd5;
	localparam logic [2:0] EV_REFUSED = 3'd6;

	localparam logic [15:0] SCALE_SEC = 16'd1000;
	localparam logic [15:0] SCALE_MIN = 16'd60000;

	typedef struct packed {
		logic load_in;
		logic grant;
		logic mul;
		logic sleep_wr;
		logic wait_wr;
		logic scan_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       unit_ok;
		logic       sid_ok;
		logic       empty;
		logic       scan_last;
		logic       out_free;
	} status_t;

endpackage

FILE: hw/rtl/twtt_ctrl.sv
module twtt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  twtt_pkg::status_t st,
	output twtt_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DECODE   = 7'b0000010,
		ST_GRANT    = 7'b0000100,
		ST_SCALE    = 7'b0001000,
		ST_SLEEP_WR = 7'b0010000,
		ST_WAIT_WR  = 7'b0100000,
		ST_SCAN     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (st.func)
					twtt_pkg::FN_REGISTER: state_d = ST_GRANT;
					twtt_pkg::FN_SLEEP: state_d = (st.sid_ok && st.unit_ok) ? ST_SCALE : ST_IDLE;
					twtt_pkg::FN_WAIT: state_d = st.sid_ok ? ST_WAIT_WR : ST_IDLE;
					twtt_pkg::FN_SCAN: state_d = st.empty ? ST_IDLE : ST_SCAN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_GRANT: begin
				if (st.out_free) begin
					cmd.grant = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCALE: begin
				cmd.mul = 1'b1;
				state_d = ST_SLEEP_WR;
			end
			ST_SLEEP_WR: begin
				cmd.sleep_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_WAIT_WR: begin
				cmd.wait_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (st.out_free) begin
					cmd.scan_step = 1'b1;
					if (st.scan_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_grant_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.grant || cmd.scan_step) |-> st.out_free)
		else $error("Result loaded while the output register is still held.");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !st.empty)
		else $error("Scan step with no registered slot.");

	a_sleep_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sleep_wr |-> $past(cmd.mul))
		else $error("Sleep entry written without a fresh product.");

endmodule

FILE: hw/rtl/twtt_dp.sv
module twtt_dp #(
	parameter int SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  twtt_pkg::cmd_t    cmd,
	output twtt_pkg::status_t st,
	input  logic [1:0]        func,
	input  logic [2:0]        slot_id,
	input  logic [31:0]       amount,
	input  logic [1:0]        unit,
	input  logic [31:0]       now_ms,
	input  logic [7:0]        cond_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        slot_out,
	output logic [2:0]        event_res,
	output logic              last
);

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam logic [IDXW+2:0] SLOTS_W = (IDXW + 3)'(SLOTS);
	localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);

	logic [1:0]  func_q;
	logic [2:0]  sid_q;
	logic [31:0] amount_q;
	logic [1:0]  unit_q;
	logic [31:0] now_q;
	logic [7:0]  cond_q;
	logic [47:0] prod_q;

	logic [CNTW-1:0] used_q;
	logic [IDXW-1:0] idx_q;

	logic [1:0]  mode_q  [SLOTS];
	logic [31:0] start_q [SLOTS];
	logic [31:0] len_q   [SLOTS];

	logic            out_valid_q;
	logic [2:0]      slot_out_q;
	logic [2:0]      event_q;
	logic            last_q;

	logic [IDXW+2:0] sid_wide;
	logic [IDXW+2:0] idx_wide;
	logic [CNTW+2:0] used_wide;
	logic [IDXW-1:0] sid_idx;
	logic            full;
	logic            out_free;
	logic            scan_last;
	logic [15:0]     factor;
	logic [31:0]     sleep_len;
	logic [31:0]     elapsed;
	logic            due;
	logic            cond_bit;
	logic [2:0]      scan_ev;

	assign sid_wide  = (IDXW + 3)'(sid_q);
	assign idx_wide  = (IDXW + 3)'(idx_q);
	assign used_wide = (CNTW + 3)'(used_q);
	assign sid_idx   = sid_wide[IDXW-1:0];
	assign full      = (used_q == SLOTS_C);
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_last = ((CNTW'(idx_q) + CNTW'(1)) == used_q);

	assign st.func      = func_q;
	assign st.unit_ok   = (unit_q != twtt_pkg::UNIT_BAD);
	assign st.sid_ok    = (sid_wide < SLOTS_W);
	assign st.empty     = (used_q == '0);
	assign st.scan_last = scan_last;
	assign st.out_free  = out_free;

	assign factor = (unit_q == twtt_pkg::UNIT_SEC) ? twtt_pkg::SCALE_SEC : twtt_pkg::SCALE_MIN;
	assign sleep_len = (unit_q == twtt_pkg::UNIT_MS) ? amount_q :
		((prod_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : prod_q[31:0]);

	assign elapsed  = now_q - start_q[idx_q];
	assign due      = (elapsed >= len_q[idx_q]);
	assign cond_bit = (idx_wide[IDXW+2:3] == '0) ? cond_q[idx_wide[2:0]] : 1'b0;

	always_comb begin
		scan_ev = twtt_pkg::EV_IDLE;
		case (mode_q[idx_q])
			twtt_pkg::MODE_RUN: scan_ev = twtt_pkg::EV_RUN;
			twtt_pkg::MODE_SLEEP: begin
				if (due) begin
					scan_ev = twtt_pkg::EV_EXPIRED;
				end
			end
			twtt_pkg::MODE_WAIT: begin
				if ((len_q[idx_q] != 32'd0) && due) begin
					scan_ev = twtt_pkg::EV_TIMEOUT;
				end else if (cond_bit) begin
					scan_ev = twtt_pkg::EV_COND;
				end
			end
			default: scan_ev = twtt_pkg::EV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= func;
			sid_q    <= slot_id;
			amount_q <= amount;
			unit_q   <= unit;
			now_q    <= now_ms;
			cond_q   <= cond_ready;
		end
		if (cmd.mul) begin
			prod_q <= amount_q * factor;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grant && !full) begin
			mode_q[used_q[IDXW-1:0]]  <= twtt_pkg::MODE_RUN;
			start_q[used_q[IDXW-1:0]] <= 32'd0;
			len_q[used_q[IDXW-1:0]]   <= 32'd0;
		end
		if (cmd.sleep_wr) begin
			mode_q[sid_idx]  <= twtt_pkg::MODE_SLEEP;
			start_q[sid_idx] <= now_q;
			len_q[sid_idx]   <= sleep_len;
		end
		if (cmd.wait_wr) begin
			mode_q[sid_idx]  <= twtt_pkg::MODE_WAIT;
			start_q[sid_idx] <= now_q;
			len_q[sid_idx]   <= amount_q;
		end
		if (cmd.scan_step && (scan_ev == twtt_pkg::EV_EXPIRED || scan_ev == twtt_pkg::EV_COND ||
				scan_ev == twtt_pkg::EV_TIMEOUT)) begin
			mode_q[idx_q] <= twtt_pkg::MODE_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.grant && !full) begin
				used_q <= used_q + CNTW'(1);
			end
			if (cmd.load_in) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + IDXW'(1);
			end
			if (cmd.grant || cmd.scan_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grant) begin
			slot_out_q <= full ? 3'd0 : used_wide[2:0];
			event_q    <= full ? twtt_pkg::EV_REFUSED : twtt_pkg::EV_GRANTED;
			last_q     <= 1'b1;
		end else if (cmd.scan_step) begin
			slot_out_q <= idx_wide[2:0];
			event_q    <= scan_ev;
			last_q     <= scan_last;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_out  = slot_out_q;
	assign event_res = event_q;
	assign last      = last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SLOTS_C)
		else $error("Slot count above table size.");

	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.grant && !full) |=> (used_q == $past(used_q) + CNTW'(1)))
		else $error("Granted slot did not advance the slot count.");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (CNTW'(idx_q) < used_q))
		else $error("Scan index beyond registered slots.");

endmodule

FILE: hw/rtl/task_wakeup_timer_table_core.sv
// A register item passes through decode and grant; its result is loaded into the output
// register once that register is free. A scan decodes and then loads one result per cycle
// while the output is not stalled. Sleep decodes, multiplies by the unit scale and then
// writes the slot; an unknown unit ends after decode with no write. Wait decodes and then
// writes; the scan walks the slot table one entry a cycle while the output is not stalled.
// Reset clears the slot count and the control state; the slot table itself is not cleared.
module task_wakeup_timer_table_core #(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [2:0]  slot_id,
	input  logic [31:0] amount,
	input  logic [1:0]  unit,
	input  logic [31:0] now_ms,
	input  logic [7:0]  cond_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  slot_out,
	output logic [2:0]  event_res,
	output logic        last
);

	twtt_pkg::cmd_t    cmd;
	twtt_pkg::status_t st;

	twtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	twtt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.func       (func),
		.slot_id    (slot_id),
		.amount     (amount),
		.unit       (unit),
		.now_ms     (now_ms),
		.cond_ready (cond_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_out   (slot_out),
		.event_res  (event_res),
		.last       (last)
	);

endmodule
